// File: sv/adsr_envelope_generator_unit_macros.svh
// Assertion macros shared by the envelope generator RTL.
// Relies on i_clk and i_rst_n being present in the including module.
`ifndef ADSR_ENVELOPE_GENERATOR_UNIT_MACROS_SVH
`define ADSR_ENVELOPE_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define AEG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define AEG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/aeg_pkg.sv
// Package for the ADSR envelope generator: word types, codes, constants.
// No dependencies; imported by aeg_serial_mul and the top level.
`timescale 1ns / 1ps
`default_nettype none

package aeg_pkg;

    localparam int PHASE_BITS_DEF = 20;
    localparam int STEP_W         = 20;
    localparam int LEVEL_W        = 16;
    localparam int MUL_W          = 16;
    localparam int CFG_AW         = 4;
    localparam int CFG_DW         = 32;

    // input modes
    localparam logic [1:0] MODE_TICK    = 2'd0;
    localparam logic [1:0] MODE_TRIGGER = 2'd1;
    localparam logic [1:0] MODE_FORCE   = 2'd2;

    // envelope stages
    localparam logic [2:0] STG_ATTACK  = 3'd0;
    localparam logic [2:0] STG_DECAY   = 3'd1;
    localparam logic [2:0] STG_SUSTAIN = 3'd2;
    localparam logic [2:0] STG_RELEASE = 3'd3;
    localparam logic [2:0] STG_DEAD    = 3'd4;

    // register indexes
    localparam logic [1:0] REG_ATTACK_STEP   = 2'd0;
    localparam logic [1:0] REG_DECAY_STEP    = 2'd1;
    localparam logic [1:0] REG_SUSTAIN_LEVEL = 2'd2;
    localparam logic [1:0] REG_RELEASE_STEP  = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] peak_level;
        logic [2:0]  target_stage;
    } t_aeg_in;

    typedef struct packed {
        logic [7:0] env_value;
        logic [2:0] env_stage;
    } t_aeg_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENTER,
        ST_TICK_GO,
        ST_TICK_WAIT,
        ST_OUT
    } t_aeg_state;

    // (65535 * lv) >> 16 without a multiplier
    function automatic logic [15:0] level_less_one(input logic [15:0] lv);
        return (lv == 16'h0000) ? 16'h0000 : lv - 16'd1;
    endfunction

endpackage

`default_nettype wire

// File: sv/aeg_serial_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on aeg_pkg (MUL_W) and the shared assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "adsr_envelope_generator_unit_macros.svh"

module aeg_serial_mul import aeg_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [MUL_W-1:0]   i_mcand,
    input  wire logic [MUL_W-1:0]   i_mplier,
    output logic                    o_busy,
    output logic                    o_done,
    output logic [2*MUL_W-1:0]      o_product
);

    localparam int CNT_W = $clog2(MUL_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [MUL_W-1:0] r_mcand;
    logic [MUL_W-1:0] r_hi;
    logic [MUL_W-1:0] r_lo;
    logic [MUL_W:0]   w_sum;

    // partial sum for the current multiplier bit
    assign w_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mcand} : '0);

    // sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(MUL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift register datapath: product grows in hi, multiplier shifts out of lo
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand <= i_mcand;
            r_hi    <= '0;
            r_lo    <= i_mplier;
        end else if (r_busy) begin
            r_hi <= w_sum[MUL_W:1];
            r_lo <= {w_sum[0], r_lo[MUL_W-1:1]};
        end
    end

    assign o_busy    = r_busy;
    assign o_done    = r_done;
    assign o_product = {r_hi, r_lo};

    `AEG_ASSERT_NOW(a_start_idle, i_start, !r_busy, "multiplier started while busy")
    `AEG_ASSERT_NEXT(a_done_pulse, r_done, !r_done, "done held longer than one cycle")
    `AEG_ASSERT_NOW(a_done_after_busy, r_done, $past(r_busy), "done without a run")

endmodule

`default_nettype wire

// File: sv/adsr_envelope_generator_unit.sv
// Linear ADSR envelope generator with APB register port.
// Depends on aeg_pkg, aeg_serial_mul and the shared assertion macros.
//
// Usage:
//   Input words arrive on i_in_valid / o_in_ready / i_in_data, results leave on
//   o_out_valid / i_out_ready / o_out_data, one result word per input word.
//   Mode tick advances the envelope, trigger restarts the attack at a new
//   peak, force sets a stage (release on gate-off rescales from the output).
//   Registers (attack step, decay step, sustain level, release step) sit at APB byte
//   offsets 0, 4, 8, 12; write only while idle, the block does not enforce it.
// Timing:
//   One word is in flight at a time. The 8x16 output product and the 16x16
//   decay-entry product run on one bit-serial multiplier, one bit per cycle.
//   A tick runs the output product before its result, after the decay-entry
//   product when it also enters decay; trigger, mode 3 and most forces need no
//   product, a force into decay only the decay-entry one. The block is ready for
//   the next word in the same cycle that the result enters the output register.
// Reset: all envelope state and registers clear to zero, no word pending.
// Stall: a held result stays in the output register; the block still takes
//   and works on the next word, and waits only to hand that result over.
`timescale 1ns / 1ps
`default_nettype none
`include "adsr_envelope_generator_unit_macros.svh"

module adsr_envelope_generator_unit import aeg_pkg::*; #(
    parameter int PHASE_BITS = PHASE_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire t_aeg_in            i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_aeg_out                o_out_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [CFG_AW-1:0]  paddr,
    input  wire logic [CFG_DW-1:0]  pwdata,
    output logic [CFG_DW-1:0]       prdata,
    output logic                    pready
);

    localparam int ACC_W = ((PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W) + 1;

    // configuration registers
    logic [STEP_W-1:0]  r_attack;
    logic [STEP_W-1:0]  r_decay;
    logic [LEVEL_W-1:0] r_sustain;
    logic [STEP_W-1:0]  r_release;

    // envelope state
    t_aeg_state         r_state, n_state;
    logic [2:0]         r_stage, n_stage;
    logic [ACC_W-1:0]   r_phase, n_phase;
    logic [LEVEL_W-1:0] r_level, n_level;
    logic [7:0]         r_value, n_value;
    logic [LEVEL_W-1:0] r_scale, n_scale;
    logic [LEVEL_W-1:0] r_offset, n_offset;
    logic [STEP_W-1:0]  r_step, n_step;
    logic               r_tick_after, n_tick_after;

    // output register
    logic               r_out_valid, n_out_valid;
    t_aeg_out           r_out_data, n_out_data;

    // multiplier hookup
    logic                 w_mul_start;
    logic [MUL_W-1:0]     w_mul_a;
    logic [MUL_W-1:0]     w_mul_b;
    logic                 w_mul_busy;
    logic                 w_mul_done;
    logic [2*MUL_W-1:0]   w_prod;

    logic               w_in_acc;
    logic               w_cfg_wr;
    logic [1:0]         w_cfg_idx;
    logic [2:0]         w_next_stage;
    logic [2:0]         w_target;
    logic [7:0]         w_phase_top;
    logic [7:0]         w_o;
    logic [16:0]        w_sum;
    logic [2*MUL_W:0]   w_rem;

    aeg_serial_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_mcand   (w_mul_a),
        .i_mplier  (w_mul_b),
        .o_busy    (w_mul_busy),
        .o_done    (w_mul_done),
        .o_product (w_prod)
    );

    // APB register port
    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[CFG_AW-1:2];
    assign w_cfg_wr  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack  <= '0;
            r_decay   <= '0;
            r_sustain <= '0;
            r_release <= '0;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                REG_ATTACK_STEP:   r_attack  <= pwdata[STEP_W-1:0];
                REG_DECAY_STEP:    r_decay   <= pwdata[STEP_W-1:0];
                REG_SUSTAIN_LEVEL: r_sustain <= pwdata[LEVEL_W-1:0];
                REG_RELEASE_STEP:  r_release <= pwdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_cfg_idx)
            REG_ATTACK_STEP:   prdata = {{(CFG_DW-STEP_W){1'b0}}, r_attack};
            REG_DECAY_STEP:    prdata = {{(CFG_DW-STEP_W){1'b0}}, r_decay};
            REG_SUSTAIN_LEVEL: prdata = {{(CFG_DW-LEVEL_W){1'b0}}, r_sustain};
            REG_RELEASE_STEP:  prdata = {{(CFG_DW-STEP_W){1'b0}}, r_release};
            default:           prdata = '0;
        endcase
    end

    // shared datapath terms
    assign o_in_ready   = (r_state == ST_IDLE);
    assign w_in_acc     = i_in_valid & o_in_ready;
    assign w_next_stage = (r_stage < STG_DEAD) ? r_stage + 3'd1 : STG_DEAD;
    assign w_target     = (i_in_data.target_stage > STG_DEAD) ? STG_DEAD
                                                              : i_in_data.target_stage;
    assign w_phase_top  = r_phase[PHASE_BITS-1 -: 8];
    assign w_sum        = {1'b0, w_prod[2*MUL_W-1:MUL_W]} + {9'h000, r_offset[15:8]};
    // (65535 - S) * L = (L << 16) - L - S * L
    assign w_rem        = {1'b0, r_level, 16'h0000} - {17'h00000, r_level}
                        - {1'b0, w_prod};

    // stage sequencer
    always_comb begin
        n_state      = r_state;
        n_stage      = r_stage;
        n_phase      = r_phase;
        n_level      = r_level;
        n_value      = r_value;
        n_scale      = r_scale;
        n_offset     = r_offset;
        n_step       = r_step;
        n_tick_after = r_tick_after;
        n_out_valid  = r_out_valid & ~i_out_ready;
        n_out_data   = r_out_data;
        w_mul_start  = 1'b0;
        w_mul_a      = r_sustain;
        w_mul_b      = r_level;
        w_o          = 8'h00;

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_OUT;
                    case (i_in_data.mode)
                        MODE_TICK: begin
                            n_state = ST_TICK_GO;
                            // phase wrapped: advance the stage first
                            if (|(r_phase >> PHASE_BITS)) begin
                                n_phase = '0;
                                n_step  = '0;
                                n_stage = w_next_stage;
                                case (w_next_stage)
                                    STG_DECAY: begin
                                        w_mul_start  = 1'b1;
                                        n_tick_after = 1'b1;
                                        n_state      = ST_ENTER;
                                    end
                                    STG_SUSTAIN: begin
                                        n_offset = '0;
                                        n_scale  = r_level;
                                    end
                                    STG_DEAD: begin
                                        n_offset = '0;
                                        n_scale  = '0;
                                    end
                                    default: ;
                                endcase
                            end
                        end
                        MODE_TRIGGER: begin
                            // attack from zero: first output is always zero
                            n_stage  = STG_ATTACK;
                            n_level  = i_in_data.peak_level;
                            n_offset = '0;
                            n_scale  = level_less_one(i_in_data.peak_level);
                            n_step   = r_attack;
                            n_phase  = ACC_W'(r_attack);
                            n_value  = 8'h00;
                        end
                        MODE_FORCE: begin
                            n_stage = w_target;
                            n_phase = '0;
                            case (w_target)
                                STG_ATTACK: begin
                                    n_offset = '0;
                                    n_scale  = level_less_one(r_level);
                                    n_step   = r_attack;
                                end
                                STG_DECAY: begin
                                    w_mul_start  = 1'b1;
                                    n_tick_after = 1'b0;
                                    n_state      = ST_ENTER;
                                end
                                STG_SUSTAIN: begin
                                    n_offset = '0;
                                    n_scale  = r_level;
                                    n_step   = '0;
                                end
                                STG_RELEASE: begin
                                    n_level  = {r_value, 8'h00};
                                    n_offset = '0;
                                    n_scale  = level_less_one({r_value, 8'h00});
                                    n_step   = r_release;
                                end
                                default: begin
                                    n_offset = '0;
                                    n_scale  = '0;
                                    n_step   = '0;
                                end
                            endcase
                        end
                        default: ;
                    endcase
                end
            end

            // decay entry: S * L on the multiplier
            ST_ENTER: begin
                if (w_mul_done) begin
                    n_offset = w_prod[2*MUL_W-1:MUL_W];
                    n_scale  = w_rem[2*MUL_W-1:MUL_W];
                    n_step   = r_decay;
                    n_state  = r_tick_after ? ST_TICK_GO : ST_OUT;
                end
            end

            // pick the stage's output shape and start o * scale
            ST_TICK_GO: begin
                case (r_stage)
                    STG_ATTACK:  w_o = w_phase_top;
                    STG_DECAY,
                    STG_RELEASE: w_o = 8'd255 - w_phase_top;
                    STG_SUSTAIN: w_o = r_sustain[15:8];
                    default: begin
                        w_o      = 8'h00;
                        n_offset = '0;
                    end
                endcase
                w_mul_start = 1'b1;
                w_mul_a     = r_scale;
                w_mul_b     = {8'h00, w_o};
                n_state     = ST_TICK_WAIT;
            end

            ST_TICK_WAIT: begin
                if (w_mul_done) begin
                    n_value = (w_sum > 17'd255) ? 8'hFF : w_sum[7:0];
                    n_phase = r_phase + ACC_W'(r_step);
                    n_state = ST_OUT;
                end
            end

            // hand the result word to the output register
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid          = 1'b1;
                    n_out_data.env_value = r_value;
                    n_out_data.env_stage = r_stage;
                    n_state              = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_stage      <= STG_ATTACK;
            r_phase      <= '0;
            r_level      <= '0;
            r_value      <= '0;
            r_scale      <= '0;
            r_offset     <= '0;
            r_step       <= '0;
            r_tick_after <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_stage      <= n_stage;
            r_phase      <= n_phase;
            r_level      <= n_level;
            r_value      <= n_value;
            r_scale      <= n_scale;
            r_offset     <= n_offset;
            r_step       <= n_step;
            r_tick_after <= n_tick_after;
            r_out_valid  <= n_out_valid;
        end
    end

    // output word payload
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `AEG_ASSERT_NOW(a_ready_mul_idle, o_in_ready, !w_mul_busy, "ready while multiplier runs")
    `AEG_ASSERT_NOW(a_done_in_wait, w_mul_done, (r_state == ST_ENTER) || (r_state == ST_TICK_WAIT), "product arrived outside a wait state")
    `AEG_ASSERT_NEXT(a_trigger_zero, w_in_acc && (i_in_data.mode == MODE_TRIGGER), (r_stage == STG_ATTACK) && (r_value == 8'h00), "trigger did not restart attack")
    `AEG_ASSERT_NOW(a_out_from_seq, $rose(r_out_valid), $past(r_state == ST_OUT), "result loaded outside hand-over")

endmodule

`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for adsr_envelope_generator_unit: random and directed words,
// APB register settings, and a scoreboard that predicts every result word.
// Depends on aeg_pkg and the envelope generator RTL; reads no files.
`timescale 1ns / 1ps

import aeg_pkg::*;

// Envelope predictor plus the queue of result words still owed by the block
class envelope_checker;
    // register copies
    logic [19:0] atk_step, dec_step, rel_step;
    logic [15:0] sus_level;
    // envelope state
    logic [2:0]                stage;
    logic [PHASE_BITS_DEF:0]   phase;
    logic [15:0]               level, scale, offset;
    logic [7:0]                env_out;
    logic [19:0]               step;
    t_aeg_out                  results_due[$];
    // bookkeeping
    int                        errors, checked, wraps;
    int                        mode_seen[4];
    logic [7:0]                stages_hit;

    function new();
        atk_step = '0;
        dec_step = '0;
        rel_step = '0;
        sus_level = '0;
        stage = STG_ATTACK;
        phase = '0;
        level = '0;
        scale = '0;
        offset = '0;
        env_out = '0;
        step = '0;
        stages_hit = '0;
    endfunction

    // 16-bit fraction product, upper half kept
    static function logic [15:0] frac_mul(logic [15:0] a, logic [15:0] b);
        logic [31:0] p;
        p = 32'(a) * 32'(b);
        return p[31:16];
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] data);
        case (idx)
            REG_ATTACK_STEP:   atk_step = data[19:0];
            REG_DECAY_STEP:    dec_step = data[19:0];
            REG_SUSTAIN_LEVEL: sus_level = data[15:0];
            REG_RELEASE_STEP:  rel_step = data[19:0];
            default: ;
        endcase
    endfunction

    function logic [31:0] reg_value(logic [1:0] idx);
        case (idx)
            REG_ATTACK_STEP:   return {12'h000, atk_step};
            REG_DECAY_STEP:    return {12'h000, dec_step};
            REG_SUSTAIN_LEVEL: return {16'h0000, sus_level};
            default:           return {12'h000, rel_step};
        endcase
    endfunction

    // scale, offset and step on entry to a stage
    function void load_stage(logic [2:0] st);
        case (st)
            STG_ATTACK: begin
                offset = '0;
                scale = frac_mul(16'hFFFF, level);
                step = atk_step;
            end
            STG_DECAY: begin
                offset = frac_mul(sus_level, level);
                scale = frac_mul(16'hFFFF - sus_level, level);
                step = dec_step;
            end
            STG_SUSTAIN: begin
                offset = '0;
                scale = level;
                step = '0;
            end
            STG_RELEASE: begin
                // release restarts from whatever the output is now
                level = {env_out, 8'h00};
                offset = '0;
                scale = frac_mul(16'hFFFF, level);
                step = rel_step;
            end
            default: begin
                offset = '0;
                scale = '0;
                step = '0;
            end
        endcase
    endfunction

    // one envelope tick: wrap check, output, phase advance
    function void advance_tick();
        logic [7:0]  o;
        logic [23:0] prod;
        logic [8:0]  sum;
        if (phase[PHASE_BITS_DEF]) begin
            phase = '0;
            step = '0;
            wraps++;
            if (stage < STG_DEAD) stage = stage + 3'd1;
            // sustain to release keeps scale and offset
            if (stage == STG_DECAY || stage == STG_SUSTAIN || stage == STG_DEAD)
                load_stage(stage);
        end
        o = '0;
        case (stage)
            STG_ATTACK:             o = phase[PHASE_BITS_DEF-1 -: 8];
            STG_DECAY, STG_RELEASE: o = ~phase[PHASE_BITS_DEF-1 -: 8];
            STG_SUSTAIN:            o = sus_level[15:8];
            default:                offset = '0;
        endcase
        prod = 24'(o) * 24'(scale);
        sum = 9'(prod[23:16]) + 9'(offset[15:8]);
        env_out = (sum > 9'd255) ? 8'hFF : sum[7:0];
        phase = phase + 21'(step);
    endfunction

    // accepted input word: update the model and queue the owed result
    function void take_word(t_aeg_in w);
        logic [2:0] tgt;
        t_aeg_out   r;
        mode_seen[w.mode]++;
        case (w.mode)
            MODE_TICK: advance_tick();
            MODE_TRIGGER: begin
                env_out = '0;
                phase = '0;
                stage = STG_ATTACK;
                level = w.peak_level;
                load_stage(STG_ATTACK);
                advance_tick();
            end
            MODE_FORCE: begin
                // stages past dead clamp to dead
                tgt = (w.target_stage > STG_DEAD) ? STG_DEAD : w.target_stage;
                stage = tgt;
                phase = '0;
                load_stage(tgt);
            end
            default: ;
        endcase
        r.env_value = env_out;
        r.env_stage = stage;
        results_due.push_back(r);
    endfunction

    function void match_result(t_aeg_out got);
        t_aeg_out want;
        if (results_due.size() == 0) begin
            errors++;
            $display("%0t: result with nothing owed: value %0d stage %0d",
                     $time, got.env_value, got.env_stage);
            return;
        end
        want = results_due.pop_front();
        checked++;
        stages_hit[got.env_stage] = 1'b1;
        if (got.env_value !== want.env_value) begin
            errors++;
            $display("%0t: env_value mismatch: expected %0d, actual %0d",
                     $time, want.env_value, got.env_value);
        end
        if (got.env_stage !== want.env_stage) begin
            errors++;
            $display("%0t: env_stage mismatch: expected %0d, actual %0d",
                     $time, want.env_stage, got.env_stage);
        end
    endfunction

    function void check_reg(logic [1:0] idx, logic [31:0] got);
        if (got !== reg_value(idx)) begin
            errors++;
            $display("%0t: register %0d readback: expected %h, actual %h",
                     $time, idx, reg_value(idx), got);
        end
    endfunction

    function int pending();
        return results_due.size();
    endfunction
endclass

module tb_top;

    localparam logic [1:0] MODE_SPARE    = 2'd3;
    localparam int         RANDOM_WORDS  = 1100;
    localparam int         PHASES        = 8;
    localparam int         SETTLE_CYCLES = 40;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    t_aeg_in            i_in_data;
    logic               o_out_valid;
    logic               i_out_ready;
    t_aeg_out           o_out_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [CFG_AW-1:0]  paddr;
    logic [CFG_DW-1:0]  pwdata;
    logic [CFG_DW-1:0]  prdata;
    logic               pready;

    envelope_checker chk = new();

    int words_sent;
    int settings_used;
    int gap_odds;
    int stall_odds;
    bit quiet_tail;

    adsr_envelope_generator_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #1 i_clk = ~i_clk;

    // both handshakes observed at the edge; results are checked before new words are noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) chk.match_result(o_out_data);
            if (i_in_valid && o_in_ready) chk.take_word(i_in_data);
        end
    end

    // receiver back-pressure in random bursts
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!quiet_tail && $urandom_range(0, 99) < stall_odds) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(0, 6)) @(posedge i_clk);
        end
    end

    // hard limit on run time
    initial begin
        #2_000_000;
        $display("Timeout at %0t, %0d results outstanding", $time, chk.pending());
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic t_aeg_in make_word(logic [1:0] m, logic [15:0] pk, logic [2:0] tg);
        t_aeg_in w;
        w.mode = m;
        w.peak_level = pk;
        w.target_stage = tg;
        return w;
    endfunction

    // tick with junk in the unused fields
    function automatic t_aeg_in tick_word();
        return make_word(MODE_TICK, 16'($urandom), 3'($urandom));
    endfunction

    function automatic logic [19:0] pick_step();
        case ($urandom_range(0, 9))
            0:       return 20'h00000;
            1:       return 20'hFFFFF;
            2:       return 20'($urandom_range(1, 20'h00FFF));
            default: return 20'($urandom_range(20'h08000, 20'hFFFFF));
        endcase
    endfunction

    function automatic logic [15:0] pick_level();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int pick_odds();
        case ($urandom_range(0, 3))
            2:       return 20;
            3:       return 50;
            default: return 0;
        endcase
    endfunction

    task automatic pause_input(int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // hold the word until accepted, then maybe leave a gap
    task automatic send_word(t_aeg_in w);
        i_in_valid <= 1'b1;
        i_in_data <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (w.mode != MODE_SPARE) words_sent++;
        if (!quiet_tail && $urandom_range(0, 99) < gap_odds)
            pause_input($urandom_range(1, 7));
    endtask

    // stop sending and wait for every owed result, then let the block settle
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (chk.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        chk.set_reg(idx, data);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    // prdata sampled mid access cycle, clear of the clock edge
    task automatic apb_check(logic [1:0] idx);
        logic [31:0] got;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        got = prdata;
        @(posedge i_clk);
        chk.check_reg(idx, got);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // registers change only with nothing in flight
    task automatic configure(logic [19:0] a, logic [19:0] d, logic [15:0] s, logic [19:0] r);
        drain();
        apb_write(REG_ATTACK_STEP, {12'h000, a});
        apb_write(REG_DECAY_STEP, {12'h000, d});
        apb_write(REG_SUSTAIN_LEVEL, {16'h0000, s});
        apb_write(REG_RELEASE_STEP, {12'h000, r});
        apb_check(REG_ATTACK_STEP);
        apb_check(REG_DECAY_STEP);
        apb_check(REG_SUSTAIN_LEVEL);
        apb_check(REG_RELEASE_STEP);
        settings_used++;
    endtask

    // mostly a full note (trigger, ticks, gate-off, ticks), sometimes noise
    task automatic run_episode();
        gap_odds = pick_odds();
        stall_odds = pick_odds();
        if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(1, 5))
                send_word(make_word(2'($urandom_range(0, 3)), 16'($urandom), 3'($urandom)));
        end else begin
            send_word(make_word(MODE_TRIGGER, pick_level(), 3'($urandom)));
            repeat ($urandom_range(1, 40)) send_word(tick_word());
            if ($urandom_range(0, 99) < 20) begin
                send_word(make_word(MODE_FORCE, 16'($urandom), 3'($urandom_range(0, 7))));
                repeat ($urandom_range(1, 8)) send_word(tick_word());
            end
            send_word(make_word(MODE_FORCE, 16'($urandom), STG_RELEASE));
            repeat ($urandom_range(1, 40)) send_word(tick_word());
        end
    endtask

    initial begin
        int base;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        gap_odds = 0;
        stall_odds = 0;
        quiet_tail = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset state, spare mode, one full note at max steps, then forced stages
        send_word(tick_word());
        send_word(make_word(MODE_SPARE, 16'hFFFF, 3'd7));
        configure(20'hFFFFF, 20'hFFFFF, 16'h8000, 20'hFFFFF);
        send_word(make_word(MODE_TRIGGER, 16'hFFFF, STG_ATTACK));
        repeat (5) send_word(tick_word());
        send_word(make_word(MODE_FORCE, 16'h0000, STG_RELEASE));
        repeat (4) send_word(tick_word());
        send_word(make_word(MODE_FORCE, 16'h0000, STG_ATTACK));
        send_word(tick_word());
        send_word(make_word(MODE_FORCE, 16'h0000, STG_DECAY));
        send_word(tick_word());
        send_word(make_word(MODE_FORCE, 16'hFFFF, STG_SUSTAIN));
        send_word(make_word(MODE_FORCE, 16'hFFFF, STG_DEAD));
        // targets beyond dead
        send_word(make_word(MODE_FORCE, 16'h0000, 3'd5));
        send_word(make_word(MODE_FORCE, 16'h0000, 3'd6));
        send_word(make_word(MODE_FORCE, 16'hFFFF, 3'd7));
        send_word(make_word(MODE_TRIGGER, 16'h0000, 3'd7));
        send_word(tick_word());

        // random phases, each behind a full drain and a new register setting
        base = words_sent;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                1:       configure(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 20'hFFFFF);
                2:       configure(20'h00000, 20'h00000, 16'h0000, 20'h00000);
                3:       configure(pick_step(), pick_step(), 16'h0000, pick_step());
                default: configure(pick_step(), pick_step(), pick_level(), pick_step());
            endcase
            if (p == PHASES - 1) quiet_tail = 1'b1;
            while (words_sent - base < RANDOM_WORDS * (p + 1) / PHASES) run_episode();
        end
        drain();

        $display("Covered %0d results: %0d ticks, %0d triggers, %0d forces, %0d spare words",
                 chk.checked, chk.mode_seen[MODE_TICK], chk.mode_seen[MODE_TRIGGER],
                 chk.mode_seen[MODE_FORCE], chk.mode_seen[MODE_SPARE]);
        $display("Register settings %0d, stage wraps %0d, stages seen %b",
                 settings_used, chk.wraps, chk.stages_hit[4:0]);
        if (chk.errors == 0 && chk.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
